FILE: src/mpq_pkg.sv
// Shared types and constants for the min priority queue.
// Used by the cell, the top level and the port checker.
package mpq_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 16;
  localparam int PRIO_W  = 8;
  localparam int CAP_W   = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_PUSHED  = 2'd0,
    ST_POPPED  = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } entry_t;

  // Broadcast to every cell in a cycle
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t item;
  } cell_ctrl_t;

endpackage

FILE: src/mpq_cell.sv
// One slot of the sorted chain: holds an entry, compares it with a pushed item
// and shifts toward or away from the head. Depends on mpq_pkg.
module mpq_cell (
  input  logic                clk,
  input  mpq_pkg::cell_ctrl_t ctrl,
  input  logic                valid,
  input  logic                prev_take,
  input  mpq_pkg::entry_t     prev_entry,
  input  mpq_pkg::entry_t     next_entry,
  output logic                take,
  output mpq_pkg::entry_t     entry
);
  import mpq_pkg::*;

  // The new item goes ahead of every entry with equal or larger priority,
  // so the newest of a tie sits nearest the head.
  assign take = !valid || (ctrl.item.prio <= entry.prio);

  always_ff @(posedge clk) begin
    if (ctrl.push && take) begin
      entry <= prev_take ? prev_entry : ctrl.item;
    end else if (ctrl.pop) begin
      entry <= next_entry;
    end
  end

endmodule

FILE: src/min_priority_queue.sv
// Min priority queue built as a sorted chain of DEPTH cells, head holds the minimum.
// Throughput: one push or pop per cycle unless m_tready stalls; each cell updates
// from its neighbors in one step. Results are registered on the m_ side.
// Reset: count cleared, capacity set to 10, no output pending; no clearing pass.
// Depends on mpq_pkg and mpq_cell.
module min_priority_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,   // item_data[15:0], item_priority[23:16]
  input  logic [0:0]                  s_tuser,   // op[0]
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,   // out_data[15:0]
  output logic [3:0]                  m_tuser,   // status[1:0], is_empty[2], is_full[3]
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mpq_pkg::CAP_W-1:0]   cfg_data
);
  import mpq_pkg::*;

  logic [CAP_W-1:0] capacity;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] cap_eff;
  logic             accept;
  logic             is_pop;
  logic             full_now;
  logic             do_push;
  logic             do_pop;
  status_t          status_next;
  logic [DATA_W-1:0] data_next;
  cell_ctrl_t       ctrl;

  entry_t           cell_entry [DEPTH];
  logic             cell_take  [DEPTH];

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign is_pop    = (op_t'(s_tuser[0]) == OP_POP);

  assign cap_eff  = (CNT_W'(capacity) > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(capacity);
  assign full_now = (count >= cap_eff);
  assign do_push  = accept && !is_pop && !full_now;
  assign do_pop   = accept && is_pop && (count != '0);

  always_comb begin
    count_next  = count;
    data_next   = '0;
    status_next = ST_PUSHED;
    if (is_pop) begin
      if (count == '0) begin
        status_next = ST_EMPTY;
      end else begin
        status_next = ST_POPPED;
        data_next   = cell_entry[0].data;
        count_next  = count - CNT_W'(1);
      end
    end else begin
      if (full_now) begin
        status_next = ST_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end
  end

  // push, pop, then the item as {prio, data}
  assign ctrl = {do_push, do_pop, s_tdata[DATA_W+PRIO_W-1:DATA_W], s_tdata[DATA_W-1:0]};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   prev_take_i;
    entry_t prev_entry_i;
    entry_t next_entry_i;

    if (i == 0) begin : g_head
      assign prev_take_i  = 1'b0;
      assign prev_entry_i = ctrl.item;
    end else begin : g_body
      assign prev_take_i  = cell_take[i-1];
      assign prev_entry_i = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_entry_i = cell_entry[i];
    end else begin : g_mid
      assign next_entry_i = cell_entry[i+1];
    end

    mpq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (CNT_W'(i) < count),
      .prev_take  (prev_take_i),
      .prev_entry (prev_entry_i),
      .next_entry (next_entry_i),
      .take       (cell_take[i]),
      .entry      (cell_entry[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload: hold while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata    <= data_next;
      m_tuser[1:0] <= status_next;
      m_tuser[2] <= (count_next == '0);
      m_tuser[3] <= (count_next >= cap_eff);
    end
  end

endmodule

FILE: src/mpq_checker.sv
// Port-level checks for min_priority_queue, attached by bind below.
// Depends on mpq_pkg for status codes.
module mpq_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [3:0]  m_tuser
);
  import mpq_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1:0] == ST_EMPTY) |-> m_tuser[2])
    else $error("pop on empty without empty flag");

  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1:0] == ST_PUSHED) |-> !m_tuser[2])
    else $error("empty flag after a stored push");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1:0] != ST_POPPED) |-> (m_tdata == '0))
    else $error("data present on a result that is not a pop");

  a_dropped_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[1:0] == ST_FULL) |-> m_tuser[3])
    else $error("dropped push without full flag");

endmodule

bind min_priority_queue mpq_port_checks u_mpq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
